// File: rtl/tws_pkg.sv
// Shared constants, codes and types of the timing wheel scheduler.
package tws_pkg;

   localparam int MAX_TIMERS  = 16;
   localparam int MAX_SLOTS   = 64;
   localparam int IDX_W       = $clog2(MAX_TIMERS);
   localparam int SLOT_W      = $clog2(MAX_SLOTS);
   localparam int SLOTS_CFG_W = 7;
   localparam int TICK_W      = 16;
   localparam int CYCLE_W     = 32;
   localparam int DVD_W       = TICK_W + 1;
   localparam int CSR_IDX_W   = 1;

   localparam logic REQ_TICK     = 1'b0;
   localparam logic REQ_REGISTER = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_SLOTS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_LENGTH = 1'd1;

   typedef enum logic [1:0] {
      KIND_REGISTERED = 2'd0,
      KIND_FULL       = 2'd1,
      KIND_EXPIRED    = 2'd2,
      KIND_TICK_DONE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic               recurring;
      logic [TICK_W-1:0]  interval;
      logic [CYCLE_W-1:0] due_cycle;
      logic [SLOT_W-1:0]  due_slot;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } tbl_wr_type;

endpackage

// File: rtl/tws_div.sv
// Shared restoring divider, one quotient bit per cycle.
module tws_div import tws_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [TICK_W-1:0] divisor,
   output logic              busy,
   output logic              done,
   output logic [DVD_W-1:0]  quotient,
   output logic [TICK_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [TICK_W-1:0] dvs_ff, dvs_in;
   logic [TICK_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0]  shifted;
   logic [DVD_W-1:0]  diff;
   logic              ge;

   assign shifted = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         cnt_in = CNT_W'(DVD_W);
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
         dvd_in  = {dvd_ff[DVD_W-2:0], ge};
         rem_in  = ge ? diff[TICK_W-1:0] : shifted[TICK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign busy      = (cnt_ff != '0);
   assign done      = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy) else $error("divider started while busy");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dvs_ff)) else $error("remainder not below divisor");

endmodule

// File: rtl/tws_table.sv
// Timer entry table: one write port, one registered read port.
module tws_table import tws_pkg::*; (
   input  logic             clock,
   input  tbl_wr_type       wr,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type entry_mem_ff [MAX_TIMERS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/timing_wheel_scheduler_core.sv
// Top level of the hashed timing wheel scheduler: sequencer, wheel state and output register.
//
// A register transaction runs two divisions (interval by tick length, then slot offset by
// slot count) one after the other on a single shared divider, each giving a 17-bit quotient,
// followed by a multiply step for the absolute slot; a full table skips the divisions.
// A tick transaction scans the 16 table entries, reports each expiry, and reschedules each
// recurring timer that expires through the divider. The block accepts a new transaction
// once the previous one has loaded its last result into the output register; a stalled
// result channel holds the sequencer only when a further result is due.
module timing_wheel_scheduler_core import tws_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   input  logic [TICK_W-1:0]    req_interval,
   input  logic                 req_recurring,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic [IDX_W-1:0]     rsp_handle,
   output logic [CYCLE_W-1:0]   rsp_abs_slot,
   output logic                 rsp_last,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_EMIT_REG,
      ST_D1_GO,
      ST_D1_WAIT,
      ST_D2_GO,
      ST_D2_WAIT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SCAN_EMIT,
      ST_SCAN_NEXT,
      ST_EMIT_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [SLOTS_CFG_W-1:0] wheel_slots_ff, wheel_slots_in;
   logic [TICK_W-1:0]      tick_length_ff, tick_length_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [CYCLE_W-1:0]     cycle_ff, cycle_in;
   logic [MAX_TIMERS-1:0]  valid_ff, valid_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [TICK_W-1:0]      ivl_ff, ivl_in;
   logic                   rec_ff, rec_in;
   logic                   tick_mode_ff, tick_mode_in;
   logic                   full_ff, full_in;
   logic [DVD_W-1:0]       total_ff, total_in;
   logic [CYCLE_W-1:0]     abs_ff, abs_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   logic [IDX_W-1:0]       rsp_handle_ff, rsp_handle_in;
   logic [CYCLE_W-1:0]     rsp_abs_ff, rsp_abs_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [SLOTS_CFG_W-1:0] slots_eff;
   logic [TICK_W-1:0]      tick_eff;
   logic [SLOTS_CFG_W-1:0] slot_p1;
   logic                   free_found;
   logic [IDX_W-1:0]       free_idx;
   logic                   out_free;
   logic                   hit;

   logic                   div_start;
   logic [DVD_W-1:0]       div_dvd;
   logic [TICK_W-1:0]      div_dvs;
   logic                   div_busy;
   logic                   div_done;
   logic [DVD_W-1:0]       div_q;
   logic [TICK_W-1:0]      div_r;

   tbl_wr_type             tbl_wr;
   entry_type              tbl_rd;

   tws_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   tws_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_addr (idx_ff),
      .rd_data (tbl_rd)
   );

   assign slots_eff = (wheel_slots_ff == '0) ? SLOTS_CFG_W'(1) :
                      (wheel_slots_ff > SLOTS_CFG_W'(MAX_SLOTS)) ? SLOTS_CFG_W'(MAX_SLOTS) :
                      wheel_slots_ff;
   assign tick_eff  = (tick_length_ff == '0) ? TICK_W'(1) : tick_length_ff;
   assign slot_p1   = SLOTS_CFG_W'(slot_ff) + SLOTS_CFG_W'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign hit       = valid_ff[idx_ff] && (tbl_rd.due_slot == slot_ff) &&
                      (tbl_rd.due_cycle == cycle_ff);

   assign free_found = !(&valid_ff);

   always_comb begin
      free_idx = '0;
      for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      wheel_slots_in = wheel_slots_ff;
      tick_length_in = tick_length_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WHEEL_SLOTS: wheel_slots_in = csr_data[SLOTS_CFG_W-1:0];
            CSR_TICK_LENGTH: tick_length_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      cycle_in      = cycle_ff;
      valid_in      = valid_ff;
      idx_in        = idx_ff;
      ivl_in        = ivl_ff;
      rec_in        = rec_ff;
      tick_mode_in  = tick_mode_ff;
      full_in       = full_ff;
      total_in      = total_ff;
      abs_in        = abs_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_abs_in    = rsp_abs_ff;
      rsp_last_in   = rsp_last_ff;
      div_start     = 1'b0;
      div_dvd       = DVD_W'(ivl_ff);
      div_dvs       = tick_eff;
      tbl_wr        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ivl_in = req_interval;
               rec_in = req_recurring;
               if (req_type == REQ_REGISTER) begin
                  tick_mode_in = 1'b0;
                  full_in      = !free_found;
                  idx_in       = free_idx;
                  state_in     = free_found ? ST_D1_GO : ST_MUL;
               end else begin
                  tick_mode_in = 1'b1;
                  if (slot_p1 >= slots_eff) begin
                     slot_in  = '0;
                     cycle_in = cycle_ff + CYCLE_W'(1);
                  end else begin
                     slot_in = slot_p1[SLOT_W-1:0];
                  end
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            abs_in = cycle_ff * CYCLE_W'(slots_eff) + CYCLE_W'(slot_ff);
            if (tick_mode_ff) begin
               idx_in   = '0;
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_EMIT_REG;
            end
         end
         ST_EMIT_REG: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = full_ff ? KIND_FULL : KIND_REGISTERED;
               rsp_handle_in = full_ff ? '0 : idx_ff;
               rsp_abs_in    = abs_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_D1_GO: begin
            div_start = 1'b1;
            state_in  = ST_D1_WAIT;
         end
         ST_D1_WAIT: begin
            if (div_done) begin
               total_in = DVD_W'(slot_ff) + DVD_W'(div_q[TICK_W-1:0]);
               state_in = ST_D2_GO;
            end
         end
         ST_D2_GO: begin
            div_start = 1'b1;
            div_dvd   = total_ff;
            div_dvs   = TICK_W'(slots_eff);
            state_in  = ST_D2_WAIT;
         end
         ST_D2_WAIT: begin
            if (div_done) begin
               tbl_wr.en             = 1'b1;
               tbl_wr.addr           = idx_ff;
               tbl_wr.data.recurring = rec_ff;
               tbl_wr.data.interval  = ivl_ff;
               tbl_wr.data.due_cycle = cycle_ff + CYCLE_W'(div_q);
               tbl_wr.data.due_slot  = div_r[SLOT_W-1:0];
               valid_in[idx_ff]      = 1'b1;
               state_in              = tick_mode_ff ? ST_SCAN_NEXT : ST_MUL;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (hit) begin
               state_in = ST_SCAN_EMIT;
            end else if (idx_ff == IDX_W'(MAX_TIMERS - 1)) begin
               state_in = ST_EMIT_DONE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_EXPIRED;
               rsp_handle_in = idx_ff;
               rsp_abs_in    = abs_ff;
               rsp_last_in   = 1'b0;
               if (tbl_rd.recurring) begin
                  ivl_in   = tbl_rd.interval;
                  rec_in   = 1'b1;
                  state_in = ST_D1_GO;
               end else begin
                  valid_in[idx_ff] = 1'b0;
                  state_in         = ST_SCAN_NEXT;
               end
            end
         end
         ST_SCAN_NEXT: begin
            if (idx_ff == IDX_W'(MAX_TIMERS - 1)) begin
               state_in = ST_EMIT_DONE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_EMIT_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_TICK_DONE;
               rsp_handle_in = '0;
               rsp_abs_in    = abs_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      ivl_ff        <= ivl_in;
      rec_ff        <= rec_in;
      tick_mode_ff  <= tick_mode_in;
      full_ff       <= full_in;
      total_ff      <= total_in;
      abs_ff        <= abs_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_abs_ff    <= rsp_abs_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         wheel_slots_ff <= SLOTS_CFG_W'(8);
         tick_length_ff <= TICK_W'(1);
         slot_ff        <= '0;
         cycle_ff       <= '0;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         wheel_slots_ff <= wheel_slots_in;
         tick_length_ff <= tick_length_in;
         slot_ff        <= slot_in;
         cycle_ff       <= cycle_in;
         valid_ff       <= valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_handle   = rsp_handle_ff;
   assign rsp_abs_slot = rsp_abs_ff;
   assign rsp_last     = rsp_last_ff;

   a_scan_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_CHK) |-> (SLOTS_CFG_W'(slot_ff) < slots_eff))
      else $error("wheel slot beyond slot count during scan");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_EMIT) |-> valid_ff[idx_ff])
      else $error("expiry reported for a free entry");

   a_expired_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_EXPIRED)) |-> !rsp_last_ff)
      else $error("expiry marked as final result");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> ((state_ff == ST_D1_WAIT) || (state_ff == ST_D2_WAIT)))
      else $error("divider busy outside a division wait");

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the timing wheel scheduler core.
`timescale 1ns / 1ps

module tb_top;
   import tws_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int LONG_HOLD   = 400;
   localparam int TAIL_CYCLES = 60;

   typedef struct {
      kind_type           kind;
      logic [IDX_W-1:0]   handle;
      logic [CYCLE_W-1:0] abs_slot;
      logic               last;
   } wheel_event_type;

   class wheel_scoreboard;
      bit [SLOTS_CFG_W-1:0] slots_reg = 7'd8;
      bit [TICK_W-1:0]      tick_reg  = 16'd1;
      int unsigned          cur_slot  = 0;
      bit [CYCLE_W-1:0]     cycle     = '0;
      bit                   live      [MAX_TIMERS];
      bit                   rearm     [MAX_TIMERS];
      bit [TICK_W-1:0]      period    [MAX_TIMERS];
      bit [CYCLE_W-1:0]     due_cycle [MAX_TIMERS];
      int unsigned          due_slot  [MAX_TIMERS];
      wheel_event_type      expected_events [$];
      int errors, n_registered, n_full, n_expired, n_ticks;

      function int unsigned slot_count();
         int unsigned s;
         s = slots_reg;
         if (s == 0) s = 1;
         if (s > MAX_SLOTS) s = MAX_SLOTS;
         return s;
      endfunction

      function int unsigned tick_units();
         return (tick_reg == 0) ? 1 : tick_reg;
      endfunction

      function bit [CYCLE_W-1:0] abs_now();
         return cycle * slot_count() + cur_slot;
      endfunction

      function void arm(int i, bit [TICK_W-1:0] ivl);
         int unsigned total;
         total = cur_slot + ivl / tick_units();
         due_cycle[i] = cycle + total / slot_count();
         due_slot[i]  = total % slot_count();
      endfunction

      function void queue_event(kind_type k, int h, bit [CYCLE_W-1:0] a, logic l);
         wheel_event_type e;
         e.kind     = k;
         e.handle   = IDX_W'(h);
         e.abs_slot = a;
         e.last     = l;
         expected_events.push_back(e);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
         if (idx == CSR_WHEEL_SLOTS) slots_reg = val[SLOTS_CFG_W-1:0];
         else if (idx == CSR_TICK_LENGTH) tick_reg = val;
      endfunction

      function void predict_request(logic op, logic [TICK_W-1:0] ivl, logic rec);
         int free_idx;
         free_idx = -1;
         if (op == REQ_REGISTER) begin
            for (int i = 0; i < MAX_TIMERS; i++)
               if (!live[i] && free_idx < 0) free_idx = i;
            if (free_idx < 0) begin
               n_full++;
               queue_event(KIND_FULL, 0, abs_now(), 1'b1);
            end else begin
               live[free_idx]   = 1'b1;
               rearm[free_idx]  = rec;
               period[free_idx] = ivl;
               arm(free_idx, ivl);
               n_registered++;
               queue_event(KIND_REGISTERED, free_idx, abs_now(), 1'b1);
            end
         end else begin
            n_ticks++;
            cur_slot++;
            if (cur_slot >= slot_count()) begin
               cur_slot = 0;
               cycle++;
            end
            for (int i = 0; i < MAX_TIMERS; i++) begin
               if (live[i] && due_slot[i] == cur_slot && due_cycle[i] == cycle) begin
                  n_expired++;
                  queue_event(KIND_EXPIRED, i, abs_now(), 1'b0);
                  if (rearm[i]) arm(i, period[i]);
                  else live[i] = 1'b0;
               end
            end
            queue_event(KIND_TICK_DONE, 0, abs_now(), 1'b1);
         end
      endfunction

      function void report(string field, logic [CYCLE_W-1:0] want, logic [CYCLE_W-1:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= 40)
               $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_event(logic [1:0] k, logic [IDX_W-1:0] h, logic [CYCLE_W-1:0] a,
                                logic l);
         wheel_event_type e;
         if (expected_events.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t: unexpected result, expected none actual kind %0d handle %0d abs %0d",
                        $time, k, h, a);
            return;
         end
         e = expected_events.pop_front();
         report("kind", e.kind, k);
         report("handle", e.handle, h);
         report("abs_slot", e.abs_slot, a);
         report("last", e.last, l);
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      function int free_entries();
         int n;
         n = 0;
         foreach (live[i]) if (!live[i]) n++;
         return n;
      endfunction

      function int rearm_count();
         int n;
         n = 0;
         foreach (live[i]) if (live[i] && rearm[i]) n++;
         return n;
      endfunction

      // one-shot timers that will fire within a reachable number of ticks
      function int waiting_oneshots();
         int n, t;
         bit [CYCLE_W-1:0] d;
         n = 0;
         foreach (live[i]) begin
            d = due_cycle[i] - cycle;
            if (live[i] && !rearm[i] && due_slot[i] < slot_count() && d <= 256) begin
               t = int'(d) * int'(slot_count()) + int'(due_slot[i]) - int'(cur_slot);
               if (t > 0 && t <= 300) n++;
            end
         end
         return n;
      endfunction
   endclass

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   logic                 req_type      = REQ_TICK;
   logic [TICK_W-1:0]    req_interval  = '0;
   logic                 req_recurring = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall     = 1'b0;
   logic [1:0]           rsp_kind;
   logic [IDX_W-1:0]     rsp_handle;
   logic [CYCLE_W-1:0]   rsp_abs_slot;
   logic                 rsp_last;
   logic                 csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index     = '0;
   logic [TICK_W-1:0]    csr_data      = '0;

   wheel_scoreboard wheel_check = new;

   logic        hold_request = 1'b0;
   logic        hold_taken   = 1'b0;
   int          hold_left    = 0;
   logic [15:0] rx_cycle     = '0;
   int          idle_cycles  = 0;
   int          burst_left   = 0;
   int          short_budget = 3;
   int          n_settings   = 0;

   logic [TICK_W-1:0] first_delays [14] = '{1, 2, 2, 3, 5, 7, 8, 8, 9, 12, 14, 16, 17, 15};

   timing_wheel_scheduler_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_interval  (req_interval),
      .req_recurring (req_recurring),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_handle    (rsp_handle),
      .rsp_abs_slot  (rsp_abs_slot),
      .rsp_last      (rsp_last),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         wheel_check.check_event(rsp_kind, rsp_handle, rsp_abs_slot, rsp_last);
      rx_cycle <= rx_cycle + 16'd1;
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_taken) begin
         rsp_stall  <= 1'b1;
         hold_taken <= 1'b1;
         hold_left  <= LONG_HOLD;
      end else begin
         case (rx_cycle[8:6])
            3'd0, 3'd4: rsp_stall <= 1'b0;
            3'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
            3'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
            3'd3: rsp_stall <= (rx_cycle[1:0] == 2'd0);
            3'd5: rsp_stall <= rx_cycle[2];
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic offer(input logic op, input logic [TICK_W-1:0] ivl, input logic rec);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_type      <= op;
      req_interval  <= ivl;
      req_recurring <= rec;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      wheel_check.predict_request(op, ivl, rec);
   endtask

   task automatic advance_wheel();
      offer(REQ_TICK, TICK_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (wheel_check.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic set_wheel(input logic [TICK_W-1:0] slots, input logic [TICK_W-1:0] tick);
      wait_for_results();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_WHEEL_SLOTS;
      csr_data  <= slots;
      @(posedge clock);
      wheel_check.write_reg(CSR_WHEEL_SLOTS, slots);
      csr_index <= CSR_TICK_LENGTH;
      csr_data  <= tick;
      @(posedge clock);
      wheel_check.write_reg(CSR_TICK_LENGTH, tick);
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   task automatic drain_wheel();
      int n;
      n = 0;
      while (wheel_check.waiting_oneshots() > 0 && n < 300) begin
         advance_wheel();
         n++;
      end
   endtask

   task automatic random_traffic(input int count);
      int unsigned tick, k_max, k, rem_max, s;
      logic rec;
      repeat (count) begin
         tick = wheel_check.tick_units();
         s    = wheel_check.slot_count();
         rec  = ($urandom_range(0, 9) == 0) && (wheel_check.rearm_count() < 4);
         if ($urandom_range(0, 99) >= ((wheel_check.free_entries() == 0) ? 15 : 45)) begin
            advance_wheel();
         end else if (short_budget > 0 && wheel_check.free_entries() > 0 &&
                      $urandom_range(0, 24) == 0) begin
            short_budget--;
            offer(REQ_REGISTER, TICK_W'($urandom_range(0, tick - 1)), rec);
         end else begin
            k_max = (3 * s > 12) ? 3 * s : 12;
            if (k_max > 40) k_max = 40;
            if (k_max > 65535 / tick) k_max = 65535 / tick;
            k = $urandom_range(1, k_max);
            rem_max = 65535 - k * tick;
            if (rem_max > tick - 1) rem_max = tick - 1;
            offer(REQ_REGISTER, TICK_W'(k * tick + $urandom_range(0, rem_max)), rec);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      advance_wheel();
      offer(REQ_REGISTER, 16'd0, 1'b0);
      offer(REQ_REGISTER, 16'd3, 1'b1);
      foreach (first_delays[i]) offer(REQ_REGISTER, first_delays[i], 1'b0);
      offer(REQ_REGISTER, 16'hFFFF, 1'b1);
      repeat (6) advance_wheel();
      drain_wheel();

      set_wheel(16'd64, 16'd1);
      hold_request <= 1'b1;
      random_traffic(20);
      drain_wheel();
      while (wheel_check.cur_slot < 12) advance_wheel();

      // lower the slot count below the current slot
      set_wheel(16'd5, 16'd300);
      random_traffic(15);
      drain_wheel();

      set_wheel(16'd1, 16'd4096);
      random_traffic(10);
      wait_for_results();
      random_traffic(10);
      drain_wheel();

      set_wheel(16'd0, 16'd0);
      random_traffic(20);
      drain_wheel();

      set_wheel(16'd127, 16'd65535);
      random_traffic(15);
      drain_wheel();

      set_wheel(16'd13, TICK_W'($urandom_range(2, 200)));
      random_traffic(20);
      drain_wheel();

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d registrations, %0d full-table refusals, %0d expiries, %0d ticks",
               wheel_check.n_registered, wheel_check.n_full, wheel_check.n_expired,
               wheel_check.n_ticks);
      $display("over %0d wheel settings, slot counts 0 to 127, tick lengths 0 to 65535",
               n_settings + 1);
      if (wheel_check.errors == 0 && wheel_check.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
